FILE: src/csim_pkg.sv
// Shared constants and types for the cosine similarity stream block.
// No dependencies; used by every module in src.
package csim_pkg;

  localparam int SAMPLE_W = 16;  // width of one input sample
  localparam int OUT_W    = 16;  // width of the Q1.15 similarity
  localparam int OUT_FRAC = 15;  // fraction bits of the similarity

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [OUT_W-1:0]    sim_t;

endpackage

FILE: src/csim_acc.sv
// Running dot product and sums of squares, one pair per cycle while take is high.
// Depends on csim_pkg for the sample type.
module csim_acc #(
  parameter int MAX_CHANNELS = 1024,
  parameter int ACC_W = 43
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    take,        // pair accepted this cycle
  input  logic                    last,        // pair closes the vector
  input  csim_pkg::sample_t       first_value,
  input  csim_pkg::sample_t       second_value,
  output logic                    start,       // hand sums to the solver
  output logic signed [ACC_W-1:0] dot_next,
  output logic [ACC_W-1:0]        sq1_next,
  output logic [ACC_W-1:0]        sq2_next,
  output logic                    over_next
);

  localparam int CW = $clog2(MAX_CHANNELS + 2);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_CHANNELS);

  logic signed [ACC_W-1:0] dot_sum;
  logic [ACC_W-1:0]        sq1_sum;
  logic [ACC_W-1:0]        sq2_sum;
  logic [CW-1:0]           pair_count;
  logic [CW-1:0]           pair_count_next;
  logic signed [2*csim_pkg::SAMPLE_W-1:0] prod_ab;
  logic signed [2*csim_pkg::SAMPLE_W-1:0] prod_aa;
  logic signed [2*csim_pkg::SAMPLE_W-1:0] prod_bb;

  assign prod_ab = first_value * second_value;
  assign prod_aa = first_value * first_value;
  assign prod_bb = second_value * second_value;

  always_comb begin
    dot_next = dot_sum;
    sq1_next = sq1_sum;
    sq2_next = sq2_sum;
    // pairs beyond the limit are counted only
    if (pair_count < MAX_C) begin
      dot_next = dot_sum + ACC_W'(prod_ab);
      sq1_next = sq1_sum + ACC_W'(prod_aa);
      sq2_next = sq2_sum + ACC_W'(prod_bb);
    end
    pair_count_next = (pair_count <= MAX_C) ? pair_count + 1'b1 : pair_count;
    over_next = pair_count_next > MAX_C;
  end

  assign start = take && last;

  always_ff @(posedge clk) begin
    if (rst || start) begin
      dot_sum    <= '0;
      sq1_sum    <= '0;
      sq2_sum    <= '0;
      pair_count <= '0;
    end else if (take) begin
      dot_sum    <= dot_next;
      sq1_sum    <= sq1_next;
      sq2_sum    <= sq2_next;
      pair_count <= pair_count_next;
    end
  end

endmodule

FILE: src/csim_solve.sv
// Sequencer around one shared add/subtract unit: serial multiply, square
// root and long division, then rounding, saturation and the result register.
// Depends on csim_pkg for output format constants.
module csim_solve #(
  parameter int ACC_W = 43
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [ACC_W-1:0]    dot_in,
  input  logic [ACC_W-1:0]           sq1_in,
  input  logic [ACC_W-1:0]           sq2_in,
  input  logic                       over_in,
  output logic                       busy,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [csim_pkg::OUT_W-1:0] m_tdata,
  output logic [1:0]                 m_tuser
);

  localparam int PW = 2 * ACC_W;                 // product / radicand
  localparam int RW = ACC_W + 2;                 // remainder
  localparam int DW = ACC_W + csim_pkg::OUT_FRAC; // dividend / quotient
  localparam int SW = PW;                        // shared unit width
  localparam int STEP_W = $clog2(DW + 1);
  localparam logic [DW-1:0] POS_MAX = DW'((1 << (csim_pkg::OUT_W - 1)) - 1);
  localparam logic [DW-1:0] NEG_MAX = DW'(1 << (csim_pkg::OUT_W - 1));

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_SQRT, S_DIV, S_DONE} state_t;

  state_t           state;
  logic [STEP_W-1:0] step;
  logic [ACC_W-1:0] mcand;
  logic [ACC_W-1:0] mplier;
  logic [PW-1:0]    prod;
  logic [RW-1:0]    rem;
  logic [ACC_W-1:0] root;
  logic [DW-1:0]    dvd;
  logic             neg;
  logic             over;
  logic             zero;

  // shared unit
  logic [SW-1:0] op_x;
  logic [SW-1:0] op_y;
  logic          op_sub;
  logic [SW:0]   op_sum;
  logic [RW-1:0] rem_sh;
  logic [RW-1:0] trial;
  logic          fits;

  logic [ACC_W-1:0] mag_in;
  logic             round_up;
  logic [DW-1:0]    q_round;
  logic [csim_pkg::OUT_W-1:0] sim;

  assign mag_in = dot_in[ACC_W-1] ? ACC_W'(-dot_in) : ACC_W'(dot_in);

  always_comb begin
    rem_sh = '0;
    trial  = '0;
    op_x   = '0;
    op_y   = '0;
    op_sub = 1'b1;
    case (state)
      S_MUL: begin
        op_sub = 1'b0;
        op_x = {prod[PW-2:0], 1'b0};
        op_y = mplier[ACC_W-1] ? SW'(mcand) : '0;
      end
      S_SQRT: begin
        rem_sh = {rem[RW-3:0], prod[PW-1:PW-2]};
        trial  = {root, 2'b01};
        op_x   = SW'(rem_sh);
        op_y   = SW'(trial);
      end
      S_DIV: begin
        rem_sh = {rem[RW-2:0], dvd[DW-1]};
        op_x   = SW'(rem_sh);
        op_y   = SW'(root);
      end
      default: begin
        op_sub = 1'b1;
      end
    endcase
    op_sum = {1'b0, op_x} + {1'b0, op_sub ? ~op_y : op_y} + (SW+1)'(op_sub);
    fits   = op_sum[SW];
  end

  // round half away from zero: twice the remainder against the divisor
  assign round_up = {rem, 1'b0} >= (RW+1)'(root);
  assign q_round  = dvd + DW'(round_up);

  always_comb begin
    if (zero) begin
      sim = '0;
    end else if (!neg) begin
      sim = (q_round > POS_MAX) ? csim_pkg::OUT_W'(POS_MAX) : q_round[csim_pkg::OUT_W-1:0];
    end else begin
      sim = (q_round > NEG_MAX) ? csim_pkg::OUT_W'(NEG_MAX)
                                : csim_pkg::OUT_W'(-q_round[csim_pkg::OUT_W-1:0]);
    end
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // drop the valid once taken, unless a new result loads this cycle
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            mcand  <= sq1_in;
            mplier <= sq2_in;
            prod   <= '0;
            rem    <= '0;
            root   <= '0;
            neg    <= dot_in[ACC_W-1];
            dvd    <= {mag_in, csim_pkg::OUT_FRAC'(0)};
            over   <= over_in;
            zero   <= (sq1_in == '0) || (sq2_in == '0);
            step   <= STEP_W'(ACC_W - 1);
            state  <= ((sq1_in == '0) || (sq2_in == '0)) ? S_DONE : S_MUL;
          end
        end
        S_MUL: begin
          prod   <= op_sum[PW-1:0];
          mplier <= {mplier[ACC_W-2:0], 1'b0};
          if (step == '0) begin
            step  <= STEP_W'(ACC_W - 1);
            state <= S_SQRT;
          end else begin
            step <= step - 1'b1;
          end
        end
        S_SQRT: begin
          prod <= {prod[PW-3:0], 2'b00};
          root <= {root[ACC_W-2:0], fits};
          if (step == '0) begin
            rem   <= '0;
            step  <= STEP_W'(DW - 1);
            state <= S_DIV;
          end else begin
            rem  <= fits ? op_sum[RW-1:0] : rem_sh;
            step <= step - 1'b1;
          end
        end
        S_DIV: begin
          rem  <= fits ? op_sum[RW-1:0] : rem_sh;
          dvd  <= {dvd[DW-2:0], fits};
          step <= step - 1'b1;
          if (step == '0) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the result register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= sim;
            m_tuser  <= {over, zero};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/cosine_similarity_stream.sv
// Top level of the streaming cosine similarity block.
// Instantiates csim_acc and csim_solve; constants from csim_pkg.
//
// Usage:
//   Slave channel s_*: one request per channel of the two vectors, the two
//   signed 16-bit samples in s_tdata and s_tlast on the final channel.
//   Master channel m_*: one request per vector pair, the Q1.15 similarity
//   in m_tdata, zero_norm and overflow flags in m_tuser.
//   Pairs that are not last are taken one per cycle, while the solver is
//   idle, into the accumulators. A last pair starts the solver: shift-add
//   multiply of the two ACC_W-bit sums of squares, bit-pair square root
//   and long division to ACC_W + 15 quotient bits, all on one shared
//   add/subtract unit (ACC_W = 32 + clog2(MAX_CHANNELS + 1), 43 by
//   default). The next pair can be taken once the result is loaded into
//   the output register. A zero norm skips the arithmetic: the result is
//   loaded as soon as the output register is free.
//   s_tready is low while the solver runs. A finished result waits in the
//   output register while new pairs are already taken; a stalled receiver
//   holds only the next last pair. Reset clears the sums, the count, the
//   solver and the output valid.
module cosine_similarity_stream #(
  parameter int MAX_CHANNELS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] first_value, [31:16] second_value
  input  logic        s_tlast,   // last_channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] similarity
  output logic [1:0]  m_tuser    // [0] zero_norm, [1] overflow
);

  localparam int ACC_W = 2 * csim_pkg::SAMPLE_W + $clog2(MAX_CHANNELS + 1);

  logic                    take;
  logic                    start;
  logic                    busy;
  logic signed [ACC_W-1:0] dot_next;
  logic [ACC_W-1:0]        sq1_next;
  logic [ACC_W-1:0]        sq2_next;
  logic                    over_next;

  // accept pairs whenever the solver is free
  assign s_tready = !busy;
  assign take     = s_tvalid && s_tready;

  csim_acc #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .ACC_W        (ACC_W)
  ) u_acc (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .last         (s_tlast),
    .first_value  (csim_pkg::sample_t'(s_tdata[15:0])),
    .second_value (csim_pkg::sample_t'(s_tdata[31:16])),
    .start        (start),
    .dot_next     (dot_next),
    .sq1_next     (sq1_next),
    .sq2_next     (sq2_next),
    .over_next    (over_next)
  );

  csim_solve #(
    .ACC_W (ACC_W)
  ) u_solve (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dot_in   (dot_next),
    .sq1_in   (sq1_next),
    .sq2_in   (sq2_next),
    .over_in  (over_next),
    .busy     (busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // a last pair always hands off to the solver, which then blocks input
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input still ready after a last pair");

  // a zero norm result carries similarity zero
  a_zero_norm: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("zero norm result with nonzero similarity");

  // reset leaves no result pending
  a_reset_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

FILE: test/cosine_similarity_check.sv
// Checker for the cosine similarity stream: watches both channels, predicts
// each similarity from the accepted sample pairs and compares the results.
// Depends on csim_pkg for sample and result types.
module cosine_similarity_check #(
  parameter int MAX_CHANNELS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic [1:0]  m_tuser,
  output int          errors = 0,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    csim_pkg::sim_t similarity;
    logic zero_norm;
    logic overflow;
  } similarity_t;

  similarity_t similarity_q[$];

  // running sums of the vector pair in progress
  longint      dot_acc;
  logic [63:0] sq_first_acc;
  logic [63:0] sq_second_acc;
  int          pairs_seen;

  function automatic similarity_t solve_similarity(longint dot, logic [63:0] sq1,
                                                   logic [63:0] sq2, bit over);
    similarity_t res;
    logic [127:0] prod;
    logic [127:0] cand;
    logic [127:0] root;
    logic [127:0] num;
    logic [127:0] quo;
    logic [127:0] rem;
    logic [63:0]  mag;
    bit           neg;
    root = '0;
    prod = 128'(sq1) * 128'(sq2);
    for (int b = 63; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= prod) root = cand;
    end
    res.overflow = over;
    if (root == 0) begin
      res.similarity = '0;
      res.zero_norm  = 1'b1;
      return res;
    end
    neg = dot < 0;
    mag = neg ? 64'(-dot) : 64'(dot);
    num = 128'(mag) << csim_pkg::OUT_FRAC;
    quo = num / root;
    rem = num % root;
    // round to nearest, ties away from zero
    if (2 * rem >= root) quo++;
    if (neg) res.similarity = (quo > 32768) ? -16'sd32768 : csim_pkg::sim_t'(-quo);
    else     res.similarity = (quo > 32767) ? 16'sd32767 : csim_pkg::sim_t'(quo);
    res.zero_norm = 1'b0;
    return res;
  endfunction

  task automatic report(string what, int got, int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  assign pending = similarity_q.size();

  always @(posedge clk) begin
    csim_pkg::sample_t a;
    csim_pkg::sample_t b;
    similarity_t       want;
    if (rst) begin
      dot_acc       <= 0;
      sq_first_acc  <= '0;
      sq_second_acc <= '0;
      pairs_seen    <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        longint dot_n;
        logic [63:0] sq1_n;
        logic [63:0] sq2_n;
        int cnt_n;
        a = s_tdata[15:0];
        b = s_tdata[31:16];
        dot_n = dot_acc;
        sq1_n = sq_first_acc;
        sq2_n = sq_second_acc;
        cnt_n = pairs_seen;
        // pairs past the channel limit are counted, not summed
        if (cnt_n < MAX_CHANNELS) begin
          dot_n += longint'(a) * longint'(b);
          sq1_n += 64'(longint'(a) * longint'(a));
          sq2_n += 64'(longint'(b) * longint'(b));
        end
        if (cnt_n <= MAX_CHANNELS) cnt_n++;
        if (s_tlast) begin
          similarity_q.push_back(solve_similarity(dot_n, sq1_n, sq2_n,
                                                  cnt_n > MAX_CHANNELS));
          dot_n = 0;
          sq1_n = '0;
          sq2_n = '0;
          cnt_n = 0;
        end
        dot_acc       <= dot_n;
        sq_first_acc  <= sq1_n;
        sq_second_acc <= sq2_n;
        pairs_seen    <= cnt_n;
      end
      if (m_tvalid && m_tready) begin
        if (similarity_q.size() == 0) begin
          report("unexpected result", $signed(m_tdata), 0);
        end else begin
          want = similarity_q.pop_front();
          if (m_tdata !== want.similarity)
            report("similarity", $signed(m_tdata), want.similarity);
          if (m_tuser[0] !== want.zero_norm)
            report("zero_norm", m_tuser[0], want.zero_norm);
          if (m_tuser[1] !== want.overflow)
            report("overflow", m_tuser[1], want.overflow);
        end
      end
    end
  end

endmodule

FILE: test/cosine_similarity_stream_test.sv
// Top of the cosine similarity stream testbench: clock, reset, stimulus
// and verdict. Depends on csim_pkg, cosine_similarity_stream and the checker.
module cosine_similarity_stream_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CHANNELS = 1024;
  localparam int RANDOM_ITEMS = 830;
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int IDLE_LIMIT   = 3000;  // solver run plus hold-off, with margin
  localparam int DRAIN_CYCLES = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;    // [15:0] first_value, [31:16] second_value
  logic        s_tlast = 1'b0;  // last_channel
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // [15:0] similarity
  logic [1:0]  m_tuser;         // [0] zero_norm, [1] overflow
  int          errors;
  int          pending;
  int          burst_left = 0;
  int          idle_cycles = 0;
  bit          hold_request = 1'b0;

  always #2 clk = ~clk;

  cosine_similarity_stream #(.MAX_CHANNELS(MAX_CHANNELS)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  cosine_similarity_check #(.MAX_CHANNELS(MAX_CHANNELS)) i_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .errors(errors), .pending(pending)
  );

  // Receiver: stall in runs of its own, sometimes never; on request hold
  // off for a long stretch so the block backs up into its input.
  initial begin
    int mode;
    int run;
    forever begin
      mode = $urandom_range(0, 3);
      run  = $urandom_range(5, 60);
      repeat (run) begin
        @(posedge clk);
        if (hold_request) begin
          m_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_request = 1'b0;
        end
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          2: m_tready <= $urandom_range(0, 1);
          default: m_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Offer one request, idling between bursts; hold until accepted.
  task automatic send_pair(csim_pkg::sample_t first, csim_pkg::sample_t second, bit last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {second, first};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
  endtask

  function automatic csim_pkg::sample_t pick_sample(int kind);
    case (kind)
      0: return csim_pkg::sample_t'($urandom_range(0, 65535));
      1: return csim_pkg::sample_t'($urandom_range(0, 15) - 8);
      2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      3: return '0;
      default: return csim_pkg::sample_t'($urandom_range(0, 2047) - 1024);
    endcase
  endfunction

  initial begin
    int                sent;
    int                len;
    int                shape;
    csim_pkg::sample_t a;
    csim_pkg::sample_t b;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: full-scale equal samples saturate at +1.0
    send_pair(16'sh8000, 16'sh8000, 1'b1);
    // opposite extremes land near -1.0
    send_pair(16'sh8000, 16'sh7fff, 1'b1);
    send_pair(16'sh7fff, 16'sh8000, 1'b0);
    send_pair(16'sh8000, 16'sh7fff, 1'b1);
    // exactly -1.0
    send_pair(16'sd1234, -16'sd1234, 1'b0);
    send_pair(-16'sd77, 16'sd77, 1'b1);
    // zero norm: both vectors zero, then one side zero
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(16'sd0, 16'sd0, 1'b0);
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(16'sd500, 16'sd0, 1'b0);
    send_pair(-16'sd3, 16'sd0, 1'b1);
    send_pair(16'sd0, 16'sh8000, 1'b1);
    // orthogonal vectors give zero, then two single-pair frames of opposite sign
    send_pair(16'sd1, 16'sd0, 1'b0);
    send_pair(16'sd0, 16'sd1, 1'b1);
    send_pair(16'sd1, 16'sd1, 1'b0);
    send_pair(16'sd1, -16'sd1, 1'b1);
    send_pair(16'sh5555, 16'shaaaa, 1'b1);
    send_pair(16'shffff, 16'sh0001, 1'b1);

    // Random frames, mostly short; the receiver holds off once mid-way.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent > RANDOM_ITEMS / 3 && sent < RANDOM_ITEMS / 3 + 10) hold_request = 1'b1;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      shape = $urandom_range(0, 5);
      for (int i = 0; i < len; i++) begin
        a = pick_sample($urandom_range(0, 5));
        case (shape)
          0: b = a;
          1: b = -a;
          2: b = csim_pkg::sample_t'(a + $urandom_range(0, 63) - 32);
          default: b = pick_sample($urandom_range(0, 5));
        endcase
        send_pair(a, b, i == len - 1);
        sent++;
      end
    end
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/csim_pkg.sv
src/csim_acc.sv
src/csim_solve.sv
src/cosine_similarity_stream.sv
test/cosine_similarity_check.sv
test/cosine_similarity_stream_test.sv
